// ===== src/dcrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte fold for the delta encoder.
// No dependencies; used by every module of the block.
package dcrc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // beat queue: one data beat plus two trailer beats must fit behind one waiting beat
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned FRAME_BEATS = 3;

   typedef struct packed {
      logic       push;
      logic       frame_end;
      logic [7:0] enc_byte;
      logic [15:0] crc;
   } enc_result_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               room;
   } queue_status_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/delta_encoder_crc16_trailer_core.sv =====
// Top level of the byte delta encoder with CRC-16 trailer.
// Depends on dcrc_pkg, dcrc_encoder and dcrc_beat_queue.
//
// Usage:
//   req_* carries raw frame bytes, one per beat; req_tlast marks the final
//   byte. rsp_* carries coded bytes: the first byte of a frame raw, each
//   later byte as its mod-256 difference from the previous raw byte, and
//   after the final byte the CRC-16 (init FFFF, poly 1021, no final XOR)
//   high byte then low byte, the low byte with rsp_tlast set.
//   An accepted byte is coded combinationally and written into the output queue that drives rsp_*.
//   Throughput is one byte per cycle while the queue has room; a frame-end byte yields
//   three beats, so req_tready stays low while the trailer drains.
//   req_tready depends only on the fill of a four-beat output queue, never
//   on rsp_tready, so a byte is taken while an earlier beat waits.
//   When the receiver stalls, the queue holds its beats and req_tready
//   drops once fewer than three slots are free.
//   Reset clears the queue and starts a new frame with the CRC at FFFF.
module delta_encoder_crc16_trailer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   dcrc_pkg::enc_result_type   result;
   dcrc_pkg::queue_status_type status;
   logic                       req_accept;
   logic                       rsp_accept;

   assign req_tready = status.room;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = (status.level != '0);
   assign rsp_accept = rsp_tvalid & rsp_tready;

   dcrc_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_tdata),
      .frame_end (req_tlast),
      .result    (result)
   );

   dcrc_beat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .pop       (rsp_accept),
      .head_byte (rsp_tdata),
      .head_last (rsp_tlast),
      .status    (status)
   );

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= dcrc_pkg::LEVEL_W'(dcrc_pkg::QUEUE_DEPTH))
      else $error("beat queue overfilled");

   a_trailer_queued: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> status.level >= dcrc_pkg::LEVEL_W'(2))
      else $error("frame trailer not queued");

   a_beat_appears: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted byte produced no beat");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && status.level ==
         dcrc_pkg::LEVEL_W'(dcrc_pkg::QUEUE_DEPTH - 1) |-> !req_accept)
      else $error("byte accepted without trailer room");

endmodule

// ===== src/dcrc_encoder.sv =====
// Frame state, delta coding and running CRC for one accepted byte per cycle.
// Depends on dcrc_pkg for the CRC fold and the result struct.
module dcrc_encoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    frame_end,
   output dcrc_pkg::enc_result_type result
);

   logic [7:0]  prev_ff, prev_in;
   logic        start_ff, start_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  enc;
   logic [15:0] crc_next;

   always_comb begin
      enc      = start_ff ? data_byte : data_byte - prev_ff;
      crc_next = dcrc_pkg::crc_fold(crc_ff, enc);
      prev_in  = prev_ff;
      start_in = start_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (frame_end) begin
            prev_in  = 8'h00;
            start_in = 1'b1;
            crc_in   = dcrc_pkg::CRC_INIT;
         end else begin
            prev_in  = data_byte;
            start_in = 1'b0;
            crc_in   = crc_next;
         end
      end
      result.push      = accept;
      result.frame_end = frame_end;
      result.enc_byte  = enc;
      result.crc       = crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 8'h00;
         start_ff <= 1'b1;
         crc_ff   <= dcrc_pkg::CRC_INIT;
      end else begin
         prev_ff  <= prev_in;
         start_ff <= start_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

// ===== src/dcrc_beat_queue.sv =====
// Output beat queue: takes one coded byte, or one byte plus the CRC trailer,
// per cycle and hands out one beat per cycle while pop is high. Depends on dcrc_pkg.
module dcrc_beat_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  dcrc_pkg::enc_result_type  result,
   input  logic                      pop,
   output logic [7:0]                head_byte,
   output logic                      head_last,
   output dcrc_pkg::queue_status_type status
);

   localparam int unsigned PW = dcrc_pkg::PTR_W;
   localparam int unsigned LW = dcrc_pkg::LEVEL_W;

   logic [8:0]    mem [dcrc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;
   logic [LW-1:0] push_n;
   logic [LW-1:0] pop_n;

   always_comb begin
      push_n = '0;
      if (result.push) begin
         push_n = result.frame_end ? LW'(dcrc_pkg::FRAME_BEATS) : LW'(1);
      end
      pop_n     = pop ? LW'(1) : '0;
      level_in  = level_ff + push_n - pop_n;
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop_n);
   end

   always_ff @(posedge clock) begin
      if (result.push) begin
         mem[wr_ptr_ff] <= {1'b0, result.enc_byte};
         if (result.frame_end) begin
            mem[wr_ptr_ff + PW'(1)] <= {1'b0, result.crc[15:8]};
            mem[wr_ptr_ff + PW'(2)] <= {1'b1, result.crc[7:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head_byte    = mem[rd_ptr_ff][7:0];
   assign head_last    = mem[rd_ptr_ff][8];
   assign status.level = level_ff;
   assign status.room  = (level_ff <= LW'(dcrc_pkg::QUEUE_DEPTH - dcrc_pkg::FRAME_BEATS));

endmodule
